// File: hw/rtl/hrpt_pkg.sv
// Shared types, constants and helpers of the hot region profile table.
package hrpt_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned REGION_SPAN = 16;

  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned USED_W      = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned HANDLE_W    = 32;
  localparam int unsigned ENTRY_SEL_W = 6;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CNT_W-1:0] CNT_MAX      = '1;
  localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(100);

  typedef enum logic [1:0] {
    MODE_PROFILING = 2'd0,
    MODE_COMPILING = 2'd1,
    MODE_COMPILED  = 2'd2,
    MODE_DISABLED  = 2'd3
  } mode_e;

  typedef enum logic [CMD_W-1:0] {
    OP_PROFILE = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_OUTCOME = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROF_EN    = 1'b0,
    CFG_HOT_THRESH = 1'b1
  } cfg_reg_e;

  // How the request is closed out by the datapath
  typedef enum logic [2:0] {
    FIN_ZERO       = 3'd0,
    FIN_PROF_HIT   = 3'd1,
    FIN_PROF_NEW   = 3'd2,
    FIN_LOOKUP_HIT = 3'd3,
    FIN_OUTCOME    = 3'd4
  } fin_e;

  typedef struct packed {
    logic [ADDR_W-1:0]   start;
    logic [CNT_W-1:0]    count;
    mode_e               mode;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic advance;
    logic finish;
    fin_e fin;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic prof_en;
    logic empty;
    logic match_prof;
    logic match_lookup;
    logic last;
    logic sel_ok;
    logic out_free;
  } dp_stat_t;

  // Address lies in the region, wrapping past the top of the address space
  function automatic logic holds(input logic [ADDR_W-1:0] addr,
                                 input logic [ADDR_W-1:0] start);
    logic [ADDR_W-1:0] off;
    off = addr - start;
    return off < ADDR_W'(REGION_SPAN);
  endfunction

endpackage

// File: hw/rtl/hrpt_req_if.sv
// Request channel: one command with its address and compile outcome fields.
interface hrpt_req_if import hrpt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [ADDR_W-1:0]      address;
  logic [ENTRY_SEL_W-1:0] entry_sel;
  logic                   compile_ok;
  logic [HANDLE_W-1:0]    handle_in;

  modport source (output valid, cmd, address, entry_sel, compile_ok, handle_in,
                  input ready);
  modport sink (input valid, cmd, address, entry_sel, compile_ok, handle_in,
                output ready);
endinterface

// File: hw/rtl/hrpt_rsp_if.sv
// Result channel: one result per request.
interface hrpt_rsp_if import hrpt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [ENTRY_SEL_W-1:0] entry_index;
  logic                   compile_request;
  logic [CNT_W-1:0]       hit_count;
  logic                   table_full;
  logic [HANDLE_W-1:0]    handle_out;

  modport source (output valid, hit, entry_index, compile_request, hit_count,
                  table_full, handle_out, input ready);
  modport sink (input valid, hit, entry_index, compile_request, hit_count,
                table_full, handle_out, output ready);
endinterface

// File: hw/rtl/hrpt_cfg_if.sv
// Configuration write channel: register index and write data.
interface hrpt_cfg_if import hrpt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/hrpt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module hrpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/hrpt_dp.sv
// Datapath: request registers, region table memory, config and result registers.
module hrpt_dp import hrpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [ADDR_W-1:0]      address_i,
  input  logic [ENTRY_SEL_W-1:0] entry_sel_i,
  input  logic                   compile_ok_i,
  input  logic [HANDLE_W-1:0]    handle_in_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   cfg_ready_o,
  input  logic                   rsp_ready_i,
  output logic                   rsp_valid_o,
  output logic                   hit_o,
  output logic [ENTRY_SEL_W-1:0] entry_index_o,
  output logic                   compile_request_o,
  output logic [CNT_W-1:0]       hit_count_o,
  output logic                   table_full_o,
  output logic [HANDLE_W-1:0]    handle_out_o,
  input  ctrl_cmd_t              ctrl_i,
  output dp_stat_t               stat_o
);

  op_e                    op_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [ENTRY_SEL_W-1:0] sel_q;
  logic                   ok_q;
  logic [HANDLE_W-1:0]    handle_q;

  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [USED_W-1:0]      used_q, used_d;
  logic                   prof_en_q;
  logic [CNT_W-1:0]       thresh_q;
  logic                   rsp_valid_q;

  logic                   hit_q, hit_d;
  logic [ENTRY_SEL_W-1:0] index_q, index_d;
  logic                   creq_q, creq_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   full_q, full_d;
  logic [HANDLE_W-1:0]    hout_q, hout_d;

  logic                   we;
  logic [IDX_W-1:0]       waddr, raddr;
  entry_t                 wdata, ent;
  logic [ENTRY_W-1:0]     rdata;

  logic                   in_region, promote, tbl_full, compiling;
  logic [CNT_W-1:0]       cnt_inc;
  logic [HANDLE_W-1:0]    new_handle;

  // Hold the index on a stall so the read data stays put
  always_comb begin
    idx_d = idx_q;
    if (ctrl_i.load) begin
      idx_d = '0;
    end else if (ctrl_i.advance) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  assign raddr = (op_q == OP_OUTCOME) ? IDX_W'(sel_q) : idx_d;

  hrpt_ram #(
    .Width (ENTRY_W),
    .Depth (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ent        = entry_t'(rdata);
  assign in_region  = holds(addr_q, ent.start);
  assign cnt_inc    = (ent.count == CNT_MAX) ? ent.count : ent.count + CNT_W'(1);
  assign promote    = (cnt_inc >= thresh_q) && (ent.mode == MODE_PROFILING);
  assign tbl_full   = (used_q == USED_W'(MAX_ENTRIES));
  assign compiling  = (ent.mode == MODE_COMPILING);
  assign new_handle = ok_q ? handle_q : '0;

  always_comb begin
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = ent;
    used_d  = used_q;
    hit_d   = 1'b0;
    index_d = '0;
    creq_d  = 1'b0;
    count_d = '0;
    full_d  = 1'b0;
    hout_d  = '0;
    if (ctrl_i.finish) begin
      case (ctrl_i.fin)
        FIN_PROF_HIT: begin
          we          = 1'b1;
          wdata.count = cnt_inc;
          if (promote) begin
            wdata.mode = MODE_COMPILING;
          end
          hit_d   = 1'b1;
          index_d = ENTRY_SEL_W'(idx_q);
          creq_d  = promote;
          count_d = cnt_inc;
        end
        FIN_PROF_NEW: begin
          if (tbl_full) begin
            full_d = 1'b1;
          end else begin
            we           = 1'b1;
            waddr        = IDX_W'(used_q);
            wdata.start  = addr_q;
            wdata.count  = CNT_W'(1);
            wdata.mode   = MODE_PROFILING;
            wdata.handle = '0;
            used_d       = used_q + USED_W'(1);
            index_d      = ENTRY_SEL_W'(used_q);
            count_d      = CNT_W'(1);
          end
        end
        FIN_LOOKUP_HIT: begin
          hit_d   = 1'b1;
          index_d = ENTRY_SEL_W'(idx_q);
          hout_d  = ent.handle;
        end
        FIN_OUTCOME: begin
          if (compiling) begin
            we           = 1'b1;
            waddr        = IDX_W'(sel_q);
            wdata.mode   = ok_q ? MODE_COMPILED : MODE_DISABLED;
            wdata.handle = new_handle;
            hit_d        = 1'b1;
            index_d      = sel_q;
            hout_d       = new_handle;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q     <= op_e'(cmd_i);
      addr_q   <= address_i;
      sel_q    <= entry_sel_i;
      ok_q     <= compile_ok_i;
      handle_q <= handle_in_i;
    end
    if (ctrl_i.finish) begin
      hit_q   <= hit_d;
      index_q <= index_d;
      creq_q  <= creq_d;
      count_q <= count_d;
      full_q  <= full_d;
      hout_q  <= hout_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      used_q      <= '0;
      prof_en_q   <= 1'b1;
      thresh_q    <= THRESH_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      used_q <= used_d;
      if (ctrl_i.finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PROF_EN:    prof_en_q <= cfg_data_i[0];
          CFG_HOT_THRESH: thresh_q  <= cfg_data_i[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign cfg_ready_o       = 1'b1;
  assign rsp_valid_o       = rsp_valid_q;
  assign hit_o             = hit_q;
  assign entry_index_o     = index_q;
  assign compile_request_o = creq_q;
  assign hit_count_o       = count_q;
  assign table_full_o      = full_q;
  assign handle_out_o      = hout_q;

  assign stat_o.op           = op_q;
  assign stat_o.prof_en      = prof_en_q;
  assign stat_o.empty        = (used_q == '0);
  assign stat_o.match_prof   = in_region;
  assign stat_o.match_lookup = in_region && (ent.mode == MODE_COMPILED);
  assign stat_o.last         = (USED_W'(idx_q) + USED_W'(1)) >= used_q;
  assign stat_o.sel_ok       = 32'(sel_q) < 32'(used_q);
  assign stat_o.out_free     = !rsp_valid_q || rsp_ready_i;

`ifndef SYNTHESIS
  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && table_full_o) |-> tbl_full)
    else $error("table_full reported with free entries");

  a_creq_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && compile_request_o) |-> (hit_o && hit_count_o >= thresh_q))
    else $error("compile request without a hit at threshold");
`endif

endmodule

// File: hw/rtl/hrpt_ctrl.sv
// Controller: sequences accept, table read and entry-by-entry scan.
module hrpt_ctrl import hrpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done, adv;
  fin_e       fin;

  // Decide the outcome of the entry currently on the read port
  always_comb begin
    done = 1'b0;
    adv  = 1'b0;
    fin  = FIN_ZERO;
    case (stat_i.op)
      OP_PROFILE: begin
        if (!stat_i.prof_en) begin
          done = 1'b1;
        end else if (stat_i.empty) begin
          done = 1'b1;
          fin  = FIN_PROF_NEW;
        end else if (stat_i.match_prof) begin
          done = 1'b1;
          fin  = FIN_PROF_HIT;
        end else if (stat_i.last) begin
          done = 1'b1;
          fin  = FIN_PROF_NEW;
        end else begin
          adv = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (stat_i.empty) begin
          done = 1'b1;
        end else if (stat_i.match_lookup) begin
          done = 1'b1;
          fin  = FIN_LOOKUP_HIT;
        end else if (stat_i.last) begin
          done = 1'b1;
        end else begin
          adv = 1'b1;
        end
      end
      OP_OUTCOME: begin
        done = 1'b1;
        fin  = stat_i.sel_ok ? FIN_OUTCOME : FIN_ZERO;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.fin   = fin;
    req_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (adv) begin
          cmd_o.advance = 1'b1;
        end else if (done && stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> stat_i.out_free)
    else $error("result written over an unread result");

  a_advance_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |-> (!stat_i.last && !stat_i.empty))
    else $error("scan advanced past the last used entry");

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (req_valid_i && req_ready_o))
    else $error("request loaded without a handshake");
`endif

endmodule

// File: hw/rtl/hot_region_profile_table.sv
// Hot region profile table: each request is taken in the idle state, then the
// fetch state reads the region table memory, then the scan inspects one used entry
// per cycle from index 0 up to the first match or the last used entry, writing the
// updated entry and the result in its last step; the next request can be taken the
// cycle after. A compile outcome reads only the selected entry, and a profile while
// profiling is disabled or a request on an empty table ends at the first scan step.
// The scan is paced by the single read port of the table memory, which yields one
// entry per cycle. A finished result waits in an output register; the block holds
// its last step while that register is still occupied.
module hot_region_profile_table import hrpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrpt_req_if.sink    req_i,
  hrpt_rsp_if.source  rsp_o,
  hrpt_cfg_if.sink    cfg_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  hrpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hrpt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (req_i.cmd),
    .address_i         (req_i.address),
    .entry_sel_i       (req_i.entry_sel),
    .compile_ok_i      (req_i.compile_ok),
    .handle_in_i       (req_i.handle_in),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .cfg_ready_o       (cfg_i.ready),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .hit_o             (rsp_o.hit),
    .entry_index_o     (rsp_o.entry_index),
    .compile_request_o (rsp_o.compile_request),
    .hit_count_o       (rsp_o.hit_count),
    .table_full_o      (rsp_o.table_full),
    .handle_out_o      (rsp_o.handle_out),
    .ctrl_i            (cmd),
    .stat_o            (stat)
  );

endmodule
